// ===== rtl/whl_pkg.sv =====
// ----------------------------------------------------------------------------
// whl_pkg
// Shared defaults, character codes and control types of the word length
// histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package whl_pkg;

	// Default configuration
	localparam int MAX_LENGTH_DEF = 15;
	localparam int COUNT_BITS_DEF = 32;

	// Character codes with a role of their own
	localparam logic [7:0] CH_HYPHEN     = 8'h2D;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_APOSTROPHE = 8'h27;

	// Word event from the scanner for one accepted item
	typedef struct packed {
		logic close;   // a word of nonzero length closes with this item
		logic eot;     // the item marks end of text
	} scan_event_t;

	// Report sequencer states
	typedef enum logic [1:0] {
		ST_RUN,
		ST_REQ,
		ST_LOAD,
		ST_SHOW
	} hist_state_t;

endpackage

`default_nettype wire

// ===== rtl/word_length_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// word_length_histogram_unit
// Word length histogram over a byte stream of text.
// ----------------------------------------------------------------------------
// Usage:
//   Text items enter on text_valid/text_ready with text_byte and end_of_text.
//   Ordinary bytes are taken one per cycle while text_ready is high and give
//   no result; each byte is judged one item later, once the byte after it is known.
//   An item with end_of_text set closes the open word and starts the report:
//   MAX_LENGTH result items leave on bin_valid/bin_ready, bin 1 first, with
//   last_bin set on the final bin. word_total and length_total are the same
//   in every item of the report.
//   Each report bin passes through a RAM read, a load into the output
//   register and presentation, in that order; the registered read port of
//   the bin RAM makes the load a step of its own. text_ready stays low for
//   the whole report.
//   If the receiver stalls, hold the current bin in the output register and
//   wait; nothing is lost.
//   Reset clears the lookahead, the open word, the totals and the bin valid
//   flags at once, so no clearing pass runs; the block takes text in the
//   first cycle after reset. After the last bin is taken, the block clears
//   itself the same way and accepts text again.
// ----------------------------------------------------------------------------
`default_nettype none

module word_length_histogram_unit #(
	parameter int MAX_LENGTH = whl_pkg::MAX_LENGTH_DEF,
	parameter int COUNT_BITS = whl_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// text channel
	input  wire logic                              text_valid,
	output logic                                   text_ready,
	input  wire logic [7:0]                        text_byte,
	input  wire logic                              end_of_text,
	// report channel
	output logic                                   bin_valid,
	input  wire logic                              bin_ready,
	output logic      [$clog2(MAX_LENGTH+1)-1:0]   bin_length,
	output logic      [COUNT_BITS-1:0]             bin_count,
	output logic      [COUNT_BITS-1:0]             word_total,
	output logic      [COUNT_BITS+3:0]             length_total,
	output logic                                   last_bin
);

	import whl_pkg::*;

	localparam int LW = $clog2(MAX_LENGTH + 1);

	logic          accept;
	scan_event_t   ev;
	logic [LW-1:0] close_len;

	// an item moves only when both sides agree
	assign accept = text_valid && text_ready;

	// classify bytes and track the open word
	whl_scan #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.ev          (ev),
		.close_len   (close_len)
	);

	// count closed words into the bins and walk them out at end of text
	whl_hist #(
		.MAX_LENGTH (MAX_LENGTH),
		.COUNT_BITS (COUNT_BITS)
	) u_hist (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.text_ready   (text_ready),
		.ev           (ev),
		.close_len    (close_len),
		.bin_valid    (bin_valid),
		.bin_ready    (bin_ready),
		.bin_length   (bin_length),
		.bin_count    (bin_count),
		.word_total   (word_total),
		.length_total (length_total),
		.last_bin     (last_bin)
	);

endmodule

`default_nettype wire

// ===== rtl/whl_ram.sv =====
// ----------------------------------------------------------------------------
// whl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module whl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 15
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/whl_scan.sv =====
// ----------------------------------------------------------------------------
// whl_scan
// Character classifier with one-byte lookahead; tracks the open word length
// and flags each word that closes.
// ----------------------------------------------------------------------------
`default_nettype none

module whl_scan #(
	parameter int MAX_LENGTH = whl_pkg::MAX_LENGTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire logic [7:0]                        text_byte,
	input  wire logic                              end_of_text,
	output whl_pkg::scan_event_t                   ev,
	output logic      [$clog2(MAX_LENGTH+1)-1:0]   close_len
);

	import whl_pkg::*;

	localparam int LW = $clog2(MAX_LENGTH + 1);

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_letter(c) || (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_space_or_punct(input logic [7:0] c);
		return (c inside {8'h20, [8'h09:8'h0D], [8'h21:8'h2F], [8'h3A:8'h40],
			[8'h5B:8'h60], [8'h7B:8'h7E]});
	endfunction

	logic [7:0]    look_q;
	logic          look_valid_q;
	logic [LW-1:0] len_q;

	logic [7:0]    look_d;
	logic          look_valid_d;
	logic [LW-1:0] len_d;
	logic [LW-1:0] grown;
	logic          open_word;
	logic          consume;

	assign open_word = (len_q != '0);
	assign grown     = (len_q < LW'(MAX_LENGTH)) ? len_q + LW'(1) : len_q;

	always_comb begin
		consume      = 1'b0;
		len_d        = len_q;
		ev.close     = 1'b0;
		ev.eot       = end_of_text;
		close_len    = len_q;
		look_d       = text_byte;
		look_valid_d = 1'b1;
		if (!end_of_text) begin
			if (look_valid_q) begin
				if (is_alnum(look_q)) begin
					len_d = grown;
				end else if (open_word && look_q == CH_HYPHEN && text_byte == CH_NEWLINE) begin
					consume = 1'b1;
				end else if (open_word && (look_q == CH_HYPHEN || look_q == CH_APOSTROPHE)
						&& is_letter(text_byte)) begin
					len_d = grown;
				end else if (is_space_or_punct(look_q)) begin
					ev.close = open_word;
					len_d    = '0;
				end
			end
			if (consume) begin
				look_d       = '0;
				look_valid_d = 1'b0;
			end
		end else begin
			// judge the held byte with nothing after it, then close the word
			if (look_valid_q && is_alnum(look_q)) begin
				close_len = grown;
			end
			ev.close     = (close_len != '0);
			len_d        = '0;
			look_d       = '0;
			look_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q       <= '0;
			look_valid_q <= 1'b0;
			len_q        <= '0;
		end else if (accept) begin
			look_q       <= look_d;
			look_valid_q <= look_valid_d;
			len_q        <= len_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/whl_hist.sv =====
// ----------------------------------------------------------------------------
// whl_hist
// Histogram bins in RAM with read-modify-write and forwarding, word and
// length totals, and the end-of-text report sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module whl_hist #(
	parameter int MAX_LENGTH = whl_pkg::MAX_LENGTH_DEF,
	parameter int COUNT_BITS = whl_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	output logic                                   text_ready,
	input  wire whl_pkg::scan_event_t              ev,
	input  wire logic [$clog2(MAX_LENGTH+1)-1:0]   close_len,
	output logic                                   bin_valid,
	input  wire logic                              bin_ready,
	output logic      [$clog2(MAX_LENGTH+1)-1:0]   bin_length,
	output logic      [COUNT_BITS-1:0]             bin_count,
	output logic      [COUNT_BITS-1:0]             word_total,
	output logic      [COUNT_BITS+3:0]             length_total,
	output logic                                   last_bin
);

	import whl_pkg::*;

	localparam int AW = $clog2(MAX_LENGTH);
	localparam int LW = $clog2(MAX_LENGTH + 1);
	localparam int SW = COUNT_BITS + 4;

	hist_state_t state_q, state_d;

	logic [AW-1:0]         idx_q;
	logic                  close_s1;
	logic [AW-1:0]         rd_addr_q;
	logic                  wr_valid_q;
	logic [AW-1:0]         wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;
	logic [MAX_LENGTH-1:0] valid_q;
	logic [COUNT_BITS-1:0] words_q;
	logic [SW-1:0]         sum_q;
	logic [COUNT_BITS-1:0] bin_count_q;

	logic                  close_go;
	logic                  eot_go;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] old_count;
	logic [COUNT_BITS-1:0] new_count;
	logic                  load_en;
	logic                  is_last;
	logic                  done;
	logic [SW:0]           sum_wide;

	assign close_go = accept && ev.close;
	assign eot_go   = accept && ev.eot;
	assign is_last  = (idx_q == AW'(MAX_LENGTH - 1));
	assign done     = (state_q == ST_SHOW) && bin_ready && is_last;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN:  if (eot_go) state_d = ST_REQ;
			ST_REQ:  state_d = ST_LOAD;
			ST_LOAD: state_d = ST_SHOW;
			ST_SHOW: if (bin_ready) state_d = is_last ? ST_RUN : ST_REQ;
			default: state_d = ST_RUN;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		text_ready = 1'b0;
		bin_valid  = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = idx_q;
		load_en    = 1'b0;
		case (state_q)
			ST_RUN: begin
				text_ready = 1'b1;
				rd_en      = close_go;
				rd_addr    = AW'(close_len - LW'(1));
			end
			ST_REQ:  rd_en     = 1'b1;
			ST_LOAD: load_en   = 1'b1;
			ST_SHOW: bin_valid = 1'b1;
			default: text_ready = 1'b0;
		endcase
	end

	whl_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (MAX_LENGTH)
	) u_bins (
		.clk     (clk),
		.wr_en   (close_s1),
		.wr_addr (rd_addr_q),
		.wr_data (new_count),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// forward the write of the previous cycle, unwritten bins read as zero
	always_comb begin
		if (wr_valid_q && wr_addr_q == rd_addr_q) begin
			old_count = wr_data_q;
		end else if (valid_q[rd_addr_q]) begin
			old_count = rd_data;
		end else begin
			old_count = '0;
		end
		new_count = (&old_count) ? old_count : old_count + COUNT_BITS'(1);
	end

	assign sum_wide = {1'b0, sum_q} + (SW + 1)'(close_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			idx_q      <= '0;
			close_s1   <= 1'b0;
			wr_valid_q <= 1'b0;
			valid_q    <= '0;
			words_q    <= '0;
			sum_q      <= '0;
		end else begin
			state_q    <= state_d;
			close_s1   <= close_go;
			wr_valid_q <= close_s1;
			if (close_s1) begin
				valid_q[rd_addr_q] <= 1'b1;
			end
			if (close_go) begin
				words_q <= (&words_q) ? words_q : words_q + COUNT_BITS'(1);
				sum_q   <= sum_wide[SW] ? '1 : sum_wide[SW-1:0];
			end
			if (state_q == ST_SHOW && bin_ready) begin
				idx_q <= is_last ? '0 : idx_q + AW'(1);
			end
			// report delivered: start over from cleared bins and totals
			if (done) begin
				valid_q <= '0;
				words_q <= '0;
				sum_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_addr_q <= rd_addr;
		end
		wr_addr_q <= rd_addr_q;
		wr_data_q <= new_count;
		if (load_en) begin
			bin_count_q <= old_count;
		end
	end

	assign bin_length   = LW'(idx_q) + LW'(1);
	assign bin_count    = bin_count_q;
	assign word_total   = words_q;
	assign length_total = sum_q;
	assign last_bin     = is_last;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for word_length_histogram_unit. Text items go in on the
// text channel with random gaps. A scoreboard tracks the lookahead byte, the
// open word and the bins, and queues the fifteen bins of each report. Each bin
// item taken from the block is compared with the oldest queued bin.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import whl_pkg::*;

	localparam int MAX_LEN  = MAX_LENGTH_DEF;
	localparam int CNT_BITS = COUNT_BITS_DEF;
	localparam int LEN_BITS = $clog2(MAX_LEN + 1);

	localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [CNT_BITS+3:0] SUM_MAX   = '1;

	localparam int HALF_PERIOD     = 5;
	localparam int HOLD_OFF_CYCLES = 200;   // long sink stall for the fill-up test
	localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake before giving up
	localparam int TEXT_ITEMS      = 190;   // stop the random part near this many items

	// One bin of a report as the block should present it
	typedef struct packed {
		logic [LEN_BITS-1:0] length;
		logic [CNT_BITS-1:0] count;
		logic [CNT_BITS-1:0] words;
		logic [CNT_BITS+3:0] letters;
		logic                last;
	} bin_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                text_valid  = 1'b0;
	logic                text_ready;
	logic [7:0]          text_byte   = 8'h00;
	logic                end_of_text = 1'b0;
	logic                bin_valid;
	logic                bin_ready   = 1'b0;
	logic [LEN_BITS-1:0] bin_length;
	logic [CNT_BITS-1:0] bin_count;
	logic [CNT_BITS-1:0] word_total;
	logic [CNT_BITS+3:0] length_total;
	logic                last_bin;

	// Scoreboard state: mirrors what the block holds between items
	logic [7:0]          held_byte;
	logic                held_valid;
	logic [LEN_BITS-1:0] open_length;
	logic [CNT_BITS-1:0] bin_tally [1:MAX_LEN];
	logic [CNT_BITS-1:0] word_tally;
	logic [CNT_BITS+3:0] length_sum;
	bin_report_t         expected_bins [$];

	int  error_count       = 0;
	int  text_items_sent   = 0;
	int  reports_requested = 0;
	bit  steady            = 1'b0;  // no gaps on either side while set
	bit  hold_request      = 1'b0;  // ask the sink for one long stall
	bit  hold_active       = 1'b0;

	word_length_histogram_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.bin_valid    (bin_valid),
		.bin_ready    (bin_ready),
		.bin_length   (bin_length),
		.bin_count    (bin_count),
		.word_total   (word_total),
		.length_total (length_total),
		.last_bin     (last_bin)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------------
	// Character classes, C locale
	// ------------------------------------------------------------------------
	function automatic bit is_letter(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_alnum(logic [7:0] c);
		return is_letter(c) || (c >= "0" && c <= "9");
	endfunction

	// Space, tab, newline, vertical tab, form feed, carriage return
	function automatic bit is_blank(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_mark(logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	// ------------------------------------------------------------------------
	// Scoreboard
	// ------------------------------------------------------------------------
	function automatic void clear_histogram();
		held_byte   = 8'h00;
		held_valid  = 1'b0;
		open_length = '0;
		word_tally  = '0;
		length_sum  = '0;
		for (int i = 1; i <= MAX_LEN; i++)
			bin_tally[i] = '0;
	endfunction

	// Count one more character of the open word, stopping at the top bin
	function automatic void extend_word();
		if (open_length < MAX_LEN)
			open_length++;
	endfunction

	// Book the open word, if any, into its bin and the saturating totals
	function automatic void close_word();
		if (open_length != 0) begin
			if (bin_tally[open_length] != COUNT_MAX)
				bin_tally[open_length]++;
			if (word_tally != COUNT_MAX)
				word_tally++;
			if (SUM_MAX - length_sum >= open_length)
				length_sum += open_length;
			else
				length_sum = SUM_MAX;
		end
		open_length = '0;
	endfunction

	// Classify a held byte now that the byte after it (or the end) is known.
	// Returns 1 when the next byte is swallowed too (hyphen at a line break).
	function automatic bit judge_byte(logic [7:0] c, bit has_next, logic [7:0] nxt);
		bit word_open;
		word_open = open_length != 0;
		if (is_alnum(c))
			extend_word();
		else if (word_open && c == CH_HYPHEN && has_next && nxt == CH_NEWLINE)
			return 1'b1;
		else if (word_open && (c == CH_HYPHEN || c == CH_APOSTROPHE) && has_next &&
				is_letter(nxt))
			extend_word();
		else if (is_blank(c) || is_mark(c))
			close_word();
		return 1'b0;
	endfunction

	// Advance the scoreboard by one accepted text item; queue a full report
	// when the item ends the text
	function automatic void histogram_step(logic [7:0] b, logic eot);
		bin_report_t entry;
		if (!eot) begin
			if (held_valid && judge_byte(held_byte, 1'b1, b)) begin
				held_valid = 1'b0;
				held_byte  = 8'h00;
			end else begin
				held_valid = 1'b1;
				held_byte  = b;
			end
		end else begin
			if (held_valid)
				void'(judge_byte(held_byte, 1'b0, 8'h00));
			close_word();
			for (int i = 1; i <= MAX_LEN; i++) begin
				entry.length  = LEN_BITS'(i);
				entry.count   = bin_tally[i];
				entry.words   = word_tally;
				entry.letters = length_sum;
				entry.last    = (i == MAX_LEN);
				expected_bins.push_back(entry);
			end
			clear_histogram();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Mostly back-to-back, sometimes a short gap, rarely a long pause
	function automatic int gap_length();
		int pick;
		if (steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] word_char();
		if ($urandom_range(0, 3) == 0)
			return "0" + 8'($urandom_range(0, 9));
		if ($urandom_range(0, 1) == 0)
			return "A" + 8'($urandom_range(0, 25));
		return "a" + 8'($urandom_range(0, 25));
	endfunction

	// A byte the block skips: control code outside whitespace, DEL or high byte
	function automatic logic [7:0] skipped_char();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 8));
			1: return 8'($urandom_range(14, 31));
			2: return 8'h7F;
			default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	// Offer one text item and hold it until the block takes it. Valid stays
	// high into the next item when there is no gap, so it never toggles
	// within one time step.
	task automatic send_item(input logic [7:0] b, input logic eot);
		int gap;
		gap = gap_length();
		@(negedge clk);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_valid  <= 1'b1;
		text_byte   <= b;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (text_ready !== 1'b1);
		histogram_step(b, eot);
		text_items_sent++;
		if (eot)
			reports_requested++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic end_text();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Drop valid and wait until every queued bin has been taken
	task automatic wait_reports_drained();
		@(negedge clk);
		text_valid <= 1'b0;
		while (expected_bins.size() != 0)
			@(posedge clk);
	endtask

	// A word of random letters and digits, joined now and then by a hyphen,
	// an apostrophe, a hyphen at a line break, or a skipped byte
	task automatic send_word();
		int len;
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
		for (int k = 0; k < len; k++) begin
			send_item(word_char(), 1'b0);
			if (k + 1 < len) begin
				case ($urandom_range(0, 15))
					0: send_item(CH_HYPHEN, 1'b0);
					1: send_item(CH_APOSTROPHE, 1'b0);
					2: begin
						send_item(CH_HYPHEN, 1'b0);
						send_item(CH_NEWLINE, 1'b0);
					end
					3: send_item(skipped_char(), 1'b0);
					default: ;
				endcase
			end
		end
	endtask

	task automatic send_separator();
		string marks;
		marks = "!\",.;:?()/@[]{}~";
		case ($urandom_range(0, 11))
			0, 1, 2, 3: send_item(" ", 1'b0);
			4: send_item(CH_NEWLINE, 1'b0);
			5: send_item(8'($urandom_range(9, 13)), 1'b0);
			6, 7: send_item(marks[$urandom_range(0, marks.len() - 1)], 1'b0);
			8: send_item(CH_HYPHEN, 1'b0);
			9: send_item(CH_APOSTROPHE, 1'b0);
			default: send_item(8'($urandom_range(0, 255)), 1'b0);
		endcase
	endtask

	// A run of words closed by end of text; the last word may run into the end
	task automatic send_paragraph();
		int tokens;
		tokens = $urandom_range(1, 8);
		for (int t = 0; t < tokens; t++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0);
			send_word();
			if (t + 1 < tokens || $urandom_range(0, 1) == 0)
				send_separator();
		end
		end_text();
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// End of text straight out of reset: every bin and both totals are zero
	task automatic test_empty_report();
		send_item(8'hFF, 1'b1);
	endtask

	// Joiners inside a word, a hyphen at a line break, skipped bytes inside a
	// word, a leading apostrophe, a hyphen before a digit, and a hyphen held
	// when the text ends
	task automatic test_word_rules();
		send_text("'a-b'c-\nd");
		send_item(8'h00, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(8'h80, 1'b0);
		send_text("e-1 f-");
		end_text();
	endtask

	// A word past the top bin lands in the top bin with a capped length
	task automatic test_long_word();
		send_text("0123456789abcdefg");
		end_text();
	endtask

	// No gaps on either side for a couple of paragraphs
	task automatic test_steady_stream();
		steady = 1'b1;
		send_paragraph();
		send_paragraph();
		steady = 1'b0;
	endtask

	// Sink stalls for a long stretch while a report is due and more text is
	// waiting; the block must hold its bin and stall the text channel
	task automatic test_report_backpressure();
		wait_reports_drained();
		steady = 1'b1;
		hold_request = 1'b1;
		wait (hold_active);
		send_text("fill up the report path ");
		end_text();
		repeat (3)
			send_item(word_char(), 1'b0);
		steady = 1'b0;
	endtask

	task automatic test_random_text();
		while (text_items_sent < TEXT_ITEMS || reports_requested < 8)
			send_paragraph();
	endtask

	// ------------------------------------------------------------------------
	// Report sink: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------------
	initial begin : report_sink
		int hold;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_active  = 1'b1;
				bin_ready   <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_active  = 1'b0;
			end else begin
				hold = gap_length();
				if (hold > 0) begin
					bin_ready <= 1'b0;
					repeat (hold) @(negedge clk);
				end
				bin_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Bin checker: compare each taken bin with the oldest queued one
	// ------------------------------------------------------------------------
	function automatic void check_field(string field, logic [CNT_BITS+3:0] want,
			logic [CNT_BITS+3:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : bin_checker
		bin_report_t want;
		if (arst_n && bin_valid === 1'b1 && bin_ready) begin
			if (expected_bins.size() == 0) begin
				$error("bin item with no report pending: bin_length %0d bin_count %0d",
					bin_length, bin_count);
				error_count++;
			end else begin
				want = expected_bins.pop_front();
				check_field("bin_length", (CNT_BITS + 4)'(want.length),
					(CNT_BITS + 4)'(bin_length));
				check_field("bin_count", (CNT_BITS + 4)'(want.count),
					(CNT_BITS + 4)'(bin_count));
				check_field("word_total", (CNT_BITS + 4)'(want.words),
					(CNT_BITS + 4)'(word_total));
				check_field("length_total", want.letters, length_total);
				check_field("last_bin", (CNT_BITS + 4)'(want.last),
					(CNT_BITS + 4)'(last_bin));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: give up after a long stretch with no handshake on either side
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((text_valid && text_ready === 1'b1) || (bin_valid === 1'b1 && bin_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		clear_histogram();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_empty_report();
		test_word_rules();
		test_long_word();
		test_steady_stream();
		test_report_backpressure();
		test_random_text();

		// Let the last report drain, then keep watching for any stray bin to
		// show up
		wait_reports_drained();
		repeat (3 * MAX_LEN + 20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
